>>> src/tsk_pkg.sv
// Shared constants, command and status types and exponent tables of the token sampler.
package tsk_pkg;

  localparam int VOCAB_MAX  = 32768;
  localparam int IDX_W      = 15;
  localparam int CNT_W      = 16;
  localparam int LOGIT_W    = 16;
  localparam int W_W        = 16;
  localparam int SUM_W      = 32;
  localparam int Q_W        = 12;
  localparam int TGT_W      = 48;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NUCLEUS = 8'd3;

  localparam logic [2:0] PASS_EXP   = 3'd0;
  localparam logic [2:0] PASS_KCNT  = 3'd1;
  localparam logic [2:0] PASS_KZERO = 3'd2;
  localparam logic [2:0] PASS_PSUM  = 3'd3;
  localparam logic [2:0] PASS_PGT   = 3'd4;
  localparam logic [2:0] PASS_PZERO = 3'd5;
  localparam logic [2:0] PASS_DRAW  = 3'd6;

  typedef struct packed {
    logic       load;
    logic [2:0] pass;
    logic       init;
    logic       proc;
    logic       div_step;
    logic       mul1;
    logic       mul2;
    logic       mul3;
    logic       wr;
    logic       bit_init;
    logic       bit_commit;
    logic [3:0] bit_pos;
    logic       ptgt;
    logic       dtgt;
    logic       sel_max;
    logic       sel_idx;
    logic       out_load;
    logic       clear;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic greedy;
    logic topk_en;
    logic topp_en;
    logic last_elem;
    logic big;
    logic hit;
    logic tot_zero;
  } dp_stat_t;

  function automatic logic [16:0] exp_n(input logic [3:0] n);
    case (n)
      4'd0:    exp_n = 17'd65536;
      4'd1:    exp_n = 17'd24109;
      4'd2:    exp_n = 17'd8869;
      4'd3:    exp_n = 17'd3263;
      4'd4:    exp_n = 17'd1200;
      4'd5:    exp_n = 17'd442;
      4'd6:    exp_n = 17'd162;
      4'd7:    exp_n = 17'd60;
      4'd8:    exp_n = 17'd22;
      4'd9:    exp_n = 17'd8;
      4'd10:   exp_n = 17'd3;
      4'd11:   exp_n = 17'd1;
      default: exp_n = 17'd0;
    endcase
  endfunction

  function automatic logic [16:0] exp_h(input logic [3:0] f);
    case (f)
      4'd0:    exp_h = 17'd65536;
      4'd1:    exp_h = 17'd61565;
      4'd2:    exp_h = 17'd57835;
      4'd3:    exp_h = 17'd54331;
      4'd4:    exp_h = 17'd51039;
      4'd5:    exp_h = 17'd47947;
      4'd6:    exp_h = 17'd45042;
      4'd7:    exp_h = 17'd42313;
      4'd8:    exp_h = 17'd39750;
      4'd9:    exp_h = 17'd37341;
      4'd10:   exp_h = 17'd35079;
      4'd11:   exp_h = 17'd32954;
      4'd12:   exp_h = 17'd30957;
      4'd13:   exp_h = 17'd29081;
      4'd14:   exp_h = 17'd27319;
      default: exp_h = 17'd25664;
    endcase
  endfunction

  function automatic logic [16:0] exp_l(input logic [3:0] f);
    case (f)
      4'd0:    exp_l = 17'd65536;
      4'd1:    exp_l = 17'd65280;
      4'd2:    exp_l = 17'd65026;
      4'd3:    exp_l = 17'd64772;
      4'd4:    exp_l = 17'd64520;
      4'd5:    exp_l = 17'd64268;
      4'd6:    exp_l = 17'd64018;
      4'd7:    exp_l = 17'd63768;
      4'd8:    exp_l = 17'd63520;
      4'd9:    exp_l = 17'd63272;
      4'd10:   exp_l = 17'd63025;
      4'd11:   exp_l = 17'd62780;
      4'd12:   exp_l = 17'd62535;
      4'd13:   exp_l = 17'd62291;
      4'd14:   exp_l = 17'd62048;
      default: exp_l = 17'd61806;
    endcase
  endfunction

endpackage

>>> src/tsk_dpath.sv
// Datapath of the token sampler: stores, divider, multipliers, accumulators and result register.
module tsk_dpath import tsk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic [LOGIT_W-1:0]    logit_value,
  input  logic [15:0]           random_draw,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [IDX_W-1:0]      token_index
);

  logic [1:0]         sample_mode;
  logic [15:0]        temperature;
  logic [15:0]        keep_count;
  logic [16:0]        nucleus;

  logic [LOGIT_W-1:0] logit_mem [VOCAB_MAX];
  logic [W_W-1:0]     weight_mem [VOCAB_MAX];
  logic [LOGIT_W-1:0] logit_rd;
  logic [W_W-1:0]     w_rd;

  logic [CNT_W-1:0]   cnt;
  logic [LOGIT_W-1:0] run_max;
  logic [IDX_W-1:0]   max_pos;
  logic [IDX_W-1:0]   idx;
  logic [15:0]        draw;
  logic [SUM_W-1:0]   acc;
  logic [SUM_W-1:0]   tot;
  logic [TGT_W-1:0]   tgt;
  logic [W_W-1:0]     thr;
  logic [W_W-1:0]     wv;
  logic [15:0]        rem;
  logic [Q_W-1:0]     sh;
  logic [Q_W-1:0]     quo;
  logic [33:0]        prod;
  logic [IDX_W-1:0]   res;

  logic [16:0]        diff;
  logic [19:0]        temp12;
  logic [16:0]        rem2;
  logic [W_W-1:0]     cand;
  logic [SUM_W-1:0]   acc_w;
  logic               keep_p;
  logic               w_we;
  logic [W_W-1:0]     w_wdata;
  logic [16:0]        rnd;
  logic [CNT_W-1:0]   last_pos;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_mode <= 2'd0;
      temperature <= 16'd256;
      keep_count  <= 16'd40;
      nucleus     <= 17'd62259;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:    sample_mode <= cfg_data[1:0];
        REG_TEMP:    temperature <= cfg_data[15:0];
        REG_KEEP:    keep_count  <= cfg_data[15:0];
        REG_NUCLEUS: nucleus     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    diff     = {run_max[15], run_max} - {logit_rd[15], logit_rd};
    temp12   = {1'b0, temperature, 3'b000} + {2'b00, temperature, 2'b00};
    rem2     = {rem, sh[Q_W-1]};
    cand     = thr | (16'd1 << cmd.bit_pos);
    acc_w    = acc + {16'd0, w_rd};
    last_pos = cnt - 16'd1;
    keep_p   = (w_rd > thr) ||
               ((w_rd == thr) && ({acc, 16'd0} <= tgt));
    rnd      = prod[32:16] + {16'd0, prod[15]};
    w_we     = 1'b0;
    w_wdata  = '0;
    if (cmd.wr) begin
      w_we    = 1'b1;
      w_wdata = wv;
    end else if (cmd.proc && (cmd.pass == PASS_KZERO) && (w_rd < thr)) begin
      w_we = 1'b1;
    end else if (cmd.proc && (cmd.pass == PASS_PZERO) && !keep_p) begin
      w_we = 1'b1;
    end
  end

  assign stat.empty     = (cnt == 16'd0);
  assign stat.greedy    = (sample_mode == 2'd0) || (temperature == 16'd0);
  assign stat.topk_en   = sample_mode[0] && (keep_count != 16'd0) && (cnt > keep_count);
  assign stat.topp_en   = sample_mode[1] && !nucleus[16] && (tot != '0);
  assign stat.last_elem = ({1'b0, idx} == last_pos);
  assign stat.big       = ({3'd0, diff} >= temp12);
  assign stat.hit       = ({acc_w, 16'd0} > tgt);
  assign stat.tot_zero  = (tot == '0);

  always_ff @(posedge clk) begin
    if (cmd.load && !cnt[CNT_W-1]) begin
      logit_mem[cnt[IDX_W-1:0]] <= logit_value;
    end
    logit_rd <= logit_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      weight_mem[idx] <= w_wdata;
    end
    w_rd <= weight_mem[idx];
  end

  // Vector bookkeeping.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      cnt     <= '0;
      run_max <= 16'h8000;
      max_pos <= '0;
    end else if (cmd.load && !cnt[CNT_W-1]) begin
      if ((cnt == 16'd0) || ($signed(logit_value) > $signed(run_max))) begin
        run_max <= logit_value;
        max_pos <= cnt[IDX_W-1:0];
      end
      cnt <= cnt + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      draw <= random_draw;
    end

    if (cmd.init) begin
      idx <= '0;
      if (cmd.pass != PASS_PZERO) begin
        acc <= '0;
      end
      if ((cmd.pass == PASS_EXP) || (cmd.pass == PASS_KZERO) ||
          (cmd.pass == PASS_PZERO)) begin
        tot <= '0;
      end
    end

    if (cmd.bit_init) begin
      thr <= '0;
    end
    if (cmd.bit_commit) begin
      if (cmd.pass == PASS_KCNT) begin
        if (acc >= {16'd0, keep_count}) begin
          thr <= cand;
        end
      end else if ({acc, 16'd0} > tgt) begin
        thr <= cand;
      end
    end

    if (cmd.ptgt) begin
      tgt <= {32'd0, nucleus[15:0]} * {16'd0, tot};
    end
    if (cmd.dtgt) begin
      tgt <= {32'd0, draw} * {16'd0, tot};
    end

    if (cmd.proc) begin
      case (cmd.pass)
        PASS_EXP: begin
          if (stat.big) begin
            wv <= '0;
          end else begin
            // The quotient stays below 3072, so only its low twelve bits are formed.
            rem <= {3'd0, diff[16:4]};
            sh  <= {diff[3:0], 8'h00};
            quo <= '0;
          end
        end
        PASS_KCNT: begin
          if (w_rd >= cand) begin
            acc <= acc + 32'd1;
          end
          idx <= idx + 15'd1;
        end
        PASS_KZERO: begin
          if (w_rd >= thr) begin
            tot <= tot + {16'd0, w_rd};
          end
          idx <= idx + 15'd1;
        end
        PASS_PSUM: begin
          if (w_rd >= cand) begin
            acc <= acc_w;
          end
          idx <= idx + 15'd1;
        end
        PASS_PGT: begin
          if (w_rd > thr) begin
            acc <= acc_w;
          end
          idx <= idx + 15'd1;
        end
        PASS_PZERO: begin
          // Entries equal to the cut value are kept in index order while mass remains.
          if (keep_p && (w_rd == thr)) begin
            acc <= acc + {16'd0, thr};
          end
          if (keep_p) begin
            tot <= tot + {16'd0, w_rd};
          end
          idx <= idx + 15'd1;
        end
        PASS_DRAW: begin
          acc <= acc_w;
          idx <= idx + 15'd1;
        end
        default: ;
      endcase
    end

    if (cmd.div_step) begin
      if (rem2 >= {1'b0, temperature}) begin
        rem <= 16'(rem2 - {1'b0, temperature});
        quo <= {quo[Q_W-2:0], 1'b1};
      end else begin
        rem <= rem2[15:0];
        quo <= {quo[Q_W-2:0], 1'b0};
      end
      sh <= {sh[Q_W-2:0], 1'b0};
    end
    if (cmd.mul1) begin
      prod <= exp_n(quo[11:8]) * exp_h(quo[7:4]);
    end
    if (cmd.mul2) begin
      prod <= rnd * exp_l(quo[3:0]);
    end
    if (cmd.mul3) begin
      wv <= rnd[16] ? 16'hFFFF : rnd[15:0];
    end
    if (cmd.wr) begin
      tot <= tot + {16'd0, wv};
      idx <= idx + 15'd1;
    end

    if (cmd.sel_max) begin
      res <= max_pos;
    end
    if (cmd.sel_idx) begin
      res <= idx;
    end
    if (cmd.out_load) begin
      token_index <= res;
    end
  end

endmodule

>>> src/tsk_ctrl.sv
// Sequencer of the token sampler: load phase, the passes over the stored vector and the output beat.
module tsk_ctrl import tsk_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_INIT = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_PROC = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_M1   = 4'd6;
  localparam logic [3:0] S_M2   = 4'd7;
  localparam logic [3:0] S_M3   = 4'd8;
  localparam logic [3:0] S_WR   = 4'd9;
  localparam logic [3:0] S_END  = 4'd10;
  localparam logic [3:0] S_PTGT = 4'd11;
  localparam logic [3:0] S_DTGT = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0] state, state_next;
  logic [2:0] pass, pass_next;
  logic [3:0] bitp, bitp_next;
  logic [3:0] divc, divc_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    pass_next  = pass;
    bitp_next  = bitp;
    divc_next  = divc;
    cmd        = '0;
    cmd.pass   = pass;
    cmd.bit_pos = bitp;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_next = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (stat.empty || stat.greedy) begin
          cmd.sel_max = 1'b1;
          state_next  = S_OUT;
        end else begin
          pass_next  = PASS_EXP;
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        state_next = S_PROC;
      end
      S_PROC: begin
        cmd.proc = 1'b1;
        if (pass == PASS_EXP) begin
          divc_next  = '0;
          state_next = stat.big ? S_WR : S_DIV;
        end else if ((pass == PASS_DRAW) && stat.hit) begin
          cmd.sel_idx = 1'b1;
          state_next  = S_OUT;
        end else begin
          state_next = stat.last_elem ? S_END : S_RD;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        divc_next    = divc + 4'd1;
        if (divc == 4'(Q_W - 1)) begin
          state_next = S_M1;
        end
      end
      S_M1: begin
        cmd.mul1   = 1'b1;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.mul2   = 1'b1;
        state_next = S_M3;
      end
      S_M3: begin
        cmd.mul3   = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr     = 1'b1;
        state_next = stat.last_elem ? S_END : S_RD;
      end
      S_END: begin
        case (pass)
          PASS_EXP: begin
            if (stat.topk_en) begin
              cmd.bit_init = 1'b1;
              bitp_next    = 4'd15;
              pass_next    = PASS_KCNT;
              state_next   = S_INIT;
            end else begin
              state_next = stat.topp_en ? S_PTGT : S_DTGT;
            end
          end
          PASS_KCNT, PASS_PSUM: begin
            // One threshold bit is settled per pass, from the top bit down.
            cmd.bit_commit = 1'b1;
            state_next     = S_INIT;
            if (bitp == 4'd0) begin
              pass_next = (pass == PASS_KCNT) ? PASS_KZERO : PASS_PGT;
            end else begin
              bitp_next = bitp - 4'd1;
            end
          end
          PASS_KZERO: begin
            state_next = stat.topp_en ? S_PTGT : S_DTGT;
          end
          PASS_PGT: begin
            pass_next  = PASS_PZERO;
            state_next = S_INIT;
          end
          PASS_PZERO: begin
            state_next = S_DTGT;
          end
          default: begin
            cmd.sel_max = 1'b1;
            state_next  = S_OUT;
          end
        endcase
      end
      S_PTGT: begin
        cmd.ptgt     = 1'b1;
        cmd.bit_init = 1'b1;
        bitp_next    = 4'd15;
        pass_next    = PASS_PSUM;
        state_next   = S_INIT;
      end
      S_DTGT: begin
        if (stat.tot_zero) begin
          cmd.sel_max = 1'b1;
          state_next  = S_OUT;
        end else begin
          cmd.dtgt   = 1'b1;
          pass_next  = PASS_DRAW;
          state_next = S_INIT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pass      <= PASS_EXP;
      bitp      <= '0;
      divc      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
      bitp  <= bitp_next;
      divc  <= divc_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/token_sampler_topk_topp.sv
// Top level of the top-k / top-p token sampler.
//
//   Channel   Direction  Beat carries
//   s_axis    in         one logit, last mark, uniform draw
//   m_axis    out        chosen token index, one beat per vector
//   cfg       in         register index and value
//
// Loading accepts one logit per cycle; a closing beat starts the passes over the
// stored vector, unless the vector is empty or sampling is greedy. The weight
// pass runs the entries through the divider and the table multipliers; then come
// 17 passes for top-k, 18 for top-p and one for the draw.
// Reset is synchronous; stores need no clearing. A waiting result beat does not
// stop loading of the next vector.
module token_sampler_topk_topp import tsk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,  // logit_value [15:0], random_draw [31:16]
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,  // token_index [14:0], zero [15]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [IDX_W-1:0] token_index;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {1'b0, token_index};

  tsk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tsk_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .logit_value (s_axis_tdata[15:0]),
    .random_draw (s_axis_tdata[31:16]),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .token_index (token_index)
  );

endmodule

>>> src/tsk_checker.sv
// Port-level checks of the token sampler and their binding to the top level.
module tsk_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // A stalled result beat keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !m_axis_tdata[15])
    else $error("token index out of range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat after reset");

  // Loading stops only after a beat that closes a vector.
  a_stop_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tlast))
    else $error("input stalled without a closing beat");

endmodule

bind token_sampler_topk_topp tsk_checker u_tsk_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
